// File: design/jeti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeti_pkg
// Shared types, constants and helpers for the Julia escape-time iterator.
// ----------------------------------------------------------------------------
package jeti_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int COORD_W     = 32;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int ITER_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Escape threshold is 4.0 squared-magnitude, i.e. 2^(2F+2)
    localparam int THRESH_BITS     = 2 * FRAC_BITS + 2;
    localparam bit ESC_REACHABLE   = (THRESH_BITS <= 63);
    localparam logic [PROD_W:0] ESC_LIMIT =
        ESC_REACHABLE ? ((PROD_W + 1)'(1) << THRESH_BITS) : '1;

    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(500);

    localparam int SUM_W = PROD_W + 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
    } jeti_point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
        logic [ITER_W-1:0]         max_iter;
    } jeti_cfg_t;

    typedef struct packed {
        logic              done;
        logic [ITER_W-1:0] count;
    } jeti_result_t;

    // Clamp a wide signed sum to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > hi)
            return hi[COORD_W-1:0];
        else if (v < lo)
            return lo[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

// File: design/julia_escape_time_iterator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_iterator_unit
// Julia-set escape-time counter for one starting point per request.
// ----------------------------------------------------------------------------
// Each request carries a starting point z in signed Q4.28; the unit repeats
// z = z*z + c with c from the configuration registers and returns the first
// iteration (from 1) at which |z| reaches 2, or 0 if none does within
// max_iterations. Each iteration runs through the product state of the
// back-end loop, for the three 32x32 products, and the evaluate state, for
// the update, saturation and magnitude test. A point is loaded, then takes a
// product and an evaluate step for the starting point and for each iteration;
// its last evaluate step holds until the result register is free. A two-entry
// queue takes further requests while a point iterates, and the result register
// lets the engine start the next point while a count waits to be taken.
// ----------------------------------------------------------------------------
module julia_escape_time_iterator_unit
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_write,
    input  logic [jeti_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [jeti_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic                                      point_valid,
    output logic                                      point_ready,
    input  logic signed [jeti_pkg::COORD_W-1:0]       start_real,
    input  logic signed [jeti_pkg::COORD_W-1:0]       start_imag,
    output logic                                      result_valid,
    input  logic                                      result_ready,
    output logic [jeti_pkg::ITER_W-1:0]               escape_count
);
    import jeti_pkg::*;

    jeti_cfg_t         cfg_reg;
    jeti_cfg_t         cfg_next;
    jeti_point_t       point_in;
    jeti_point_t       q_point;
    logic              q_valid;
    logic              q_pop;
    jeti_result_t      core_result;
    logic              out_free;
    logic              result_valid_reg;
    logic              result_valid_next;
    logic [ITER_W-1:0] escape_count_reg;

    assign point_in.re = start_real;
    assign point_in.im = start_imag;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_C_REAL:   cfg_next.c_real   = cfg_data[COORD_W-1:0];
                REG_C_IMAG:   cfg_next.c_imag   = cfg_data[COORD_W-1:0];
                REG_MAX_ITER: cfg_next.max_iter = cfg_data[ITER_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c_real   <= '0;
            cfg_reg.c_imag   <= '0;
            cfg_reg.max_iter <= MAX_ITER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    jeti_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_in    (point_in),
        .q_valid     (q_valid),
        .q_point     (q_point),
        .q_pop       (q_pop)
    );

    jeti_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_point  (q_point),
        .q_pop    (q_pop),
        .out_free (out_free),
        .result   (core_result)
    );

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (core_result.done)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_result.done)
            escape_count_reg <= core_result.count;
    end

    assign result_valid = result_valid_reg;
    assign escape_count = escape_count_reg;

    // A finished count never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        core_result.done |-> (!result_valid_reg || result_ready))
        else $error("result register overwritten");

    // The count never exceeds the iteration limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (escape_count_reg <= cfg_reg.max_iter))
        else $error("escape count above limit");

    // No count is issued in the cycle after a point is loaded
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_valid) |=> !core_result.done)
        else $error("result issued straight after a new point was loaded");

endmodule

// File: design/jeti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeti_front
// Request intake: takes starting points and holds them in a short queue.
// ----------------------------------------------------------------------------
module jeti_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_ready,
    input  jeti_pkg::jeti_point_t point_in,
    output logic                 q_valid,
    output jeti_pkg::jeti_point_t q_point,
    input  logic                 q_pop
);
    import jeti_pkg::*;

    jeti_point_t            slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg;
    logic [Q_PTR_W-1:0]     wr_ptr_next;
    logic [Q_PTR_W-1:0]     rd_ptr_reg;
    logic [Q_PTR_W-1:0]     rd_ptr_next;
    logic [Q_CNT_W-1:0]     level_reg;
    logic [Q_CNT_W-1:0]     level_next;
    logic                   push;
    logic                   pop;

    assign point_ready = (level_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid     = (level_reg != '0);
    assign q_point     = slot_reg[rd_ptr_reg];
    assign push        = point_valid && point_ready;
    assign pop         = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            level_next = level_reg + 1'b1;
        else if (pop && !push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= point_in;
    end

endmodule

// File: design/jeti_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeti_core
// Iteration engine: squares z, adds c and tests the magnitude, a product and an evaluate state a step.
// ----------------------------------------------------------------------------
module jeti_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  jeti_pkg::jeti_cfg_t    cfg,
    input  logic                   q_valid,
    input  jeti_pkg::jeti_point_t  q_point,
    output logic                   q_pop,
    input  logic                   out_free,
    output jeti_pkg::jeti_result_t result
);
    import jeti_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_EVAL = 3'b100
    } core_state_t;

    core_state_t              state_reg;
    core_state_t              state_next;
    logic signed [COORD_W-1:0] re_reg;
    logic signed [COORD_W-1:0] re_next;
    logic signed [COORD_W-1:0] im_reg;
    logic signed [COORD_W-1:0] im_next;
    logic [ITER_W-1:0]        iter_reg;
    logic [ITER_W-1:0]        iter_next;
    logic signed [PROD_W-1:0] re2_reg;
    logic signed [PROD_W-1:0] im2_reg;
    logic signed [PROD_W-1:0] x_reg;

    logic signed [PROD_W-1:0] re_ext;
    logic signed [PROD_W-1:0] im_ext;
    logic signed [PROD_W-1:0] diff;
    logic signed [PROD_W-1:0] diff_sh;
    logic signed [PROD_W-1:0] x_sh;
    logic signed [SUM_W-1:0]  nre_sum;
    logic signed [SUM_W-1:0]  nim_sum;
    logic [PROD_W:0]          mag;
    logic                     escaped;
    logic                     finish;

    assign re_ext  = {{(PROD_W-COORD_W){re_reg[COORD_W-1]}}, re_reg};
    assign im_ext  = {{(PROD_W-COORD_W){im_reg[COORD_W-1]}}, im_reg};

    assign diff    = re2_reg - im2_reg;
    assign diff_sh = diff >>> FRAC_BITS;
    assign x_sh    = x_reg >>> (FRAC_BITS - 1);
    assign nre_sum = {{(SUM_W-PROD_W){diff_sh[PROD_W-1]}}, diff_sh}
                   + {{(SUM_W-COORD_W){cfg.c_real[COORD_W-1]}}, cfg.c_real};
    assign nim_sum = {{(SUM_W-PROD_W){x_sh[PROD_W-1]}}, x_sh}
                   + {{(SUM_W-COORD_W){cfg.c_imag[COORD_W-1]}}, cfg.c_imag};

    // Squares of the current z are the test of the previous step
    assign mag     = {1'b0, re2_reg} + {1'b0, im2_reg};
    assign escaped = ESC_REACHABLE && (iter_reg != '0) && (mag >= ESC_LIMIT);
    assign finish  = escaped || (iter_reg == cfg.max_iter);

    assign q_pop        = (state_reg == S_IDLE);
    assign result.done  = (state_reg == S_EVAL) && finish && out_free;
    assign result.count = escaped ? iter_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    re_next    = q_point.re;
                    im_next    = q_point.im;
                    iter_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (finish)
                begin
                    // hold here until the output register can take the count
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                begin
                    re_next    = sat_coord(nre_sum);
                    im_next    = sat_coord(nim_sum);
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg   <= re_next;
        im_reg   <= im_next;
        iter_reg <= iter_next;
        if (state_reg == S_MUL)
        begin
            re2_reg <= re_ext * re_ext;
            im2_reg <= im_ext * im_ext;
            x_reg   <= re_ext * im_ext;
        end
    end

endmodule

// File: verif/escape_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_count_checker
// Watches the point and result channels and checks every escape count.
// ----------------------------------------------------------------------------
// Keeps its own copy of the configuration registers, works out the escape
// iteration of each point as it is accepted and compares the counts that come
// back, in order, with those predictions. Failures and the number of counts
// still awaited are handed to the top of the testbench.
// ----------------------------------------------------------------------------
module escape_count_checker
    import jeti_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        point_valid,
    input  logic                        point_ready,
    input  logic [COORD_W-1:0]          start_real,
    input  logic [COORD_W-1:0]          start_imag,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic [ITER_W-1:0]           escape_count,
    output int                          fail_count,
    output int                          pending_results
);

    localparam int MAX_REPORTS = 10;

    localparam int ESCAPE_EXP = 2 * FRAC_BITS + 2;
    localparam bit ESCAPE_REACHABLE = (ESCAPE_EXP <= 63);
    localparam logic [63:0] ESCAPE_LEVEL =
        ESCAPE_REACHABLE ? (64'd1 << ESCAPE_EXP) : '1;

    localparam logic signed [63:0] COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
    localparam logic signed [63:0] COORD_MIN = -(64'sd1 <<< (COORD_W - 1));

    typedef struct packed {
        logic [COORD_W-1:0] re;
        logic [COORD_W-1:0] im;
        logic [ITER_W-1:0]  count;
    } predicted_escape_t;

    predicted_escape_t  predicted_escapes[$];
    logic signed [COORD_W-1:0] c_real_reg;
    logic signed [COORD_W-1:0] c_imag_reg;
    logic [ITER_W-1:0]  max_iter_reg;
    int                 failures;

    function automatic logic signed [63:0] clamp_coord(input logic signed [63:0] v);
        if (v > COORD_MAX)
            return COORD_MAX;
        else if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // Iterate z = z*z + c and return the first iteration at which |z| >= 2
    function automatic logic [ITER_W-1:0] escape_iteration(
        input logic signed [COORD_W-1:0] re0,
        input logic signed [COORD_W-1:0] im0,
        input logic signed [COORD_W-1:0] cr,
        input logic signed [COORD_W-1:0] ci,
        input logic [ITER_W-1:0]         limit
    );
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic signed [63:0] next_re;
        logic signed [63:0] next_im;
        logic [63:0]        abs_re;
        logic [63:0]        abs_im;
        logic [63:0]        magnitude;
        logic [ITER_W-1:0]  count;
        int                 n;
        re = re0;
        im = im0;
        count = '0;
        n = 1;
        while (count == 0 && n <= limit)
        begin
            // arithmetic shifts floor towards minus infinity
            next_re = ((re * re - im * im) >>> FRAC_BITS) + cr;
            next_im = ((re * im) >>> (FRAC_BITS - 1)) + ci;
            re = clamp_coord(next_re);
            im = clamp_coord(next_im);
            abs_re = (re < 0) ? -re : re;
            abs_im = (im < 0) ? -im : im;
            magnitude = abs_re * abs_re + abs_im * abs_im;
            if (ESCAPE_REACHABLE && magnitude >= ESCAPE_LEVEL)
                count = ITER_W'(n);
            n++;
        end
        return count;
    endfunction

    task automatic log_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        predicted_escape_t head;
        predicted_escape_t entry;
        if (!rst_n)
        begin
            c_real_reg = '0;
            c_imag_reg = '0;
            max_iter_reg = MAX_ITER_RESET;
            predicted_escapes.delete();
            failures = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_C_REAL:   c_real_reg = cfg_data[COORD_W-1:0];
                    REG_C_IMAG:   c_imag_reg = cfg_data[COORD_W-1:0];
                    REG_MAX_ITER: max_iter_reg = cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end
            if (point_valid && point_ready)
            begin
                entry.re = start_real;
                entry.im = start_imag;
                entry.count = escape_iteration(start_real, start_imag,
                                               c_real_reg, c_imag_reg, max_iter_reg);
                predicted_escapes.push_back(entry);
            end
            if (result_valid && result_ready)
            begin
                if (predicted_escapes.size() == 0)
                    log_failure($sformatf("escape_count %0d arrived with no request waiting",
                                          escape_count));
                else
                begin
                    head = predicted_escapes.pop_front();
                    if (escape_count !== head.count)
                        log_failure($sformatf(
                            "escape_count for start (%h, %h): expected %0d, got %0d",
                            head.re, head.im, head.count, escape_count));
                end
            end
        end
        pending_results <= predicted_escapes.size();
        fail_count <= failures;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Julia escape-time iterator.
// ----------------------------------------------------------------------------
// Drives starting points through the request channel under a series of
// constant and iteration-limit settings: a directed part covering the field
// extremes, saturation, the exact escape threshold and the zero limit, then
// random phases mostly inside the +/-2 region. Both channels idle at random;
// two long result hold-offs fill the block. A checker beside the block does
// the prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;

    import jeti_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [COORD_W-1:0] Q_ONE   = 32'h1000_0000;
    localparam logic [COORD_W-1:0] Q_TWO   = 32'h2000_0000;
    localparam logic [COORD_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] Q_MIN   = 32'h8000_0000;

    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES     = 2 * 1023 + 8;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   point_valid;
    logic                   point_ready;
    logic [COORD_W-1:0]     start_real;
    logic [COORD_W-1:0]     start_imag;
    logic                   result_valid;
    logic                   result_ready;
    logic [ITER_W-1:0]      escape_count;

    int  fail_count;
    int  pending_results;
    int  hold_requests = 0;
    int  holds_served = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;

    julia_escape_time_iterator_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .start_real   (start_real),
        .start_imag   (start_imag),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .escape_count (escape_count)
    );

    escape_count_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .point_valid     (point_valid),
        .point_ready     (point_ready),
        .start_real      (start_real),
        .start_imag      (start_imag),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .escape_count    (escape_count),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly none or short, now and then a long one
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        int roll;
        logic [COORD_W-1:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            v = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
        else if (roll < 80)
            v = $urandom_range(0, 2 * Q_TWO) - Q_TWO;
        else if (roll < 95)
            v = $urandom();
        else
        begin
            case ($urandom_range(0, 5))
                0:       v = Q_MAX;
                1:       v = Q_MIN;
                2:       v = '0;
                3:       v = '1;
                4:       v = Q_TWO;
                default: v = -Q_TWO;
            endcase
        end
        return v;
    endfunction

    // well-known Julia constants half of the time
    task automatic choose_constant(output logic [COORD_W-1:0] cr,
                                   output logic [COORD_W-1:0] ci);
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       begin cr = -32'sd214748365; ci = 32'sd41875931;   end
                1:       begin cr = 32'sd76504105;   ci = 32'sd2684355;    end
                2:       begin cr = -32'sd107374182; ci = 32'sd161061274;  end
                3:       begin cr = -32'sd188377266; ci = -32'sd103132902; end
                default: begin cr = 32'sd95294587;   ci = 32'sd95294587;   end
            endcase
        end
        else
        begin
            cr = pick_coord();
            ci = pick_coord();
        end
    endtask

    // Keep valid high across back-to-back requests; drop it only for a gap
    task automatic send_point(input logic [COORD_W-1:0] re, input logic [COORD_W-1:0] im);
        int gap;
        gap = tx_idle ? idle_gap() : 0;
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        start_real <= re;
        start_imag <= im;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        point_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // Write all registers, ending with an index the block must ignore
    task automatic set_config(input logic [COORD_W-1:0] cr, input logic [COORD_W-1:0] ci,
                              input logic [ITER_W-1:0] limit);
        cfg_write <= 1'b1;
        cfg_index <= REG_C_REAL;
        cfg_data <= cr;
        @(posedge clk);
        cfg_index <= REG_C_IMAG;
        cfg_data <= ci;
        @(posedge clk);
        cfg_index <= REG_MAX_ITER;
        cfg_data <= {(CFG_DATA_W - ITER_W)'($urandom()), limit};
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data <= $urandom();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : result_sink
        int gap;
        result_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = (rx_idle && $urandom_range(0, 99) < 25) ? idle_gap() : 0;
                if (gap > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                else
                    result_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((point_valid && point_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[julia_escape_time_iterator_unit] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int                 p;
        int                 k;
        int                 items;
        logic [ITER_W-1:0]  limit;
        logic [COORD_W-1:0] cr;
        logic [COORD_W-1:0] ci;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        point_valid <= 1'b0;
        start_real <= '0;
        start_imag <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: c = 0, limit 500
        send_point('0, '0);
        send_point(Q_ONE, '0);
        send_point('0, Q_ONE);
        send_point(-Q_ONE, '0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MIN, '0);
        send_point('0, Q_MAX);
        send_point(Q_TWO, '0);
        send_point(32'h1800_0000, '0);
        send_point('1, 32'h0000_0001);
        send_point(32'h5555_5555, 32'hAAAA_AAAA);
        send_point(32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();

        // first iterate lands exactly on |z| = 2, then just short of it
        set_config(Q_TWO, '0, 10'd3);
        send_point('0, '0);
        wait_idle();
        set_config(Q_TWO - 1, '0, 10'd3);
        send_point('0, '0);
        send_point('0, '0);
        wait_idle();
        set_config(-Q_TWO, '0, 10'd1);
        send_point('0, '0);
        wait_idle();

        // saturating constants
        set_config(Q_MAX, Q_MIN, 10'd1);
        send_point('0, '0);
        send_point(Q_MIN, Q_MAX);
        wait_idle();
        set_config(Q_MIN, Q_MAX, 10'd0);
        send_point(Q_MAX, '0);
        send_point('0, '0);
        wait_idle();
        set_config(Q_MIN, Q_MAX, 10'd1023);
        send_point('0, '0);
        wait_idle();
        set_config(-32'sd214748365, 32'sd41875931, 10'd1023);
        send_point('0, '0);
        send_point(32'h0800_0000, 32'h0800_0000);
        send_point(32'hF000_0000, 32'h0400_0000);
        wait_idle();

        for (p = 0; p < 9; p++)
        begin
            case (p)
                0:       begin limit = 10'd1;    items = 150; end
                4:       begin limit = 10'd500;  items = 40;  end
                8:       begin limit = 10'd1023; items = 20;  end
                default: begin limit = ITER_W'($urandom_range(2, 80)); items = 165; end
            endcase
            tx_idle = (p % 3 != 2);
            rx_idle = (p % 4 != 3);
            choose_constant(cr, ci);
            set_config(cr, ci, limit);
            for (k = 0; k < items; k++)
            begin
                // hold the sender until the block has drained
                if (k == items / 2 && p % 2 == 0)
                    wait_idle();
                if (k == 10 && (p == 1 || p == 5))
                    hold_requests++;
                send_point(pick_coord(), pick_coord());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("[julia_escape_time_iterator_unit] OK");
        else
            $display("[julia_escape_time_iterator_unit] ERROR");
        $finish;
    end

endmodule
